// ===== hw/rtl/ut8e_pkg.sv =====
// shared types, constants and the code point encoder for the utf-16 to utf-8 unit
`default_nettype none
package ut8e_pkg;

    localparam int UNIT_W    = 16;
    localparam int BYTE_W    = 8;
    localparam int CP_W      = 21;
    localparam int MAX_BYTES = 6;
    localparam int CNT_W     = 3;

    localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;
    localparam logic [5:0] LOW_SURR_TAG  = 6'b110111;

    localparam logic [CP_W-1:0]   SUPP_BASE = 21'h10000;
    localparam logic [CP_W-1:0]   REPL_CP   = 21'h00fffd;
    localparam logic [BYTE_W-1:0] REPL_B0   = 8'hef;
    localparam logic [BYTE_W-1:0] REPL_B1   = 8'hbf;
    localparam logic [BYTE_W-1:0] REPL_B2   = 8'hbd;

    typedef logic [MAX_BYTES-1:0][BYTE_W-1:0] byte_vec_t;

    // one queued job: the bytes caused by one accepted unit
    typedef struct packed {
        byte_vec_t        bytes;
        logic [CNT_W-1:0] count;
        logic             eot;
    } job_t;

    typedef struct packed {
        logic [3:0][BYTE_W-1:0] b;
        logic [CNT_W-1:0]       len;
    } enc_t;

    typedef struct packed {
        logic full;
        logic valid;
    } queue_stat_t;

    function automatic enc_t encode_point(input logic [CP_W-1:0] cp);
        enc_t e;
        begin
            e.b   = '0;
            e.len = '0;
            if (cp < 21'h80) begin
                e.b[0] = {1'b0, cp[6:0]};
                e.len  = 3'd1;
            end else if (cp < 21'h800) begin
                e.b[0] = {3'b110, cp[10:6]};
                e.b[1] = {2'b10, cp[5:0]};
                e.len  = 3'd2;
            end else if (cp < SUPP_BASE) begin
                e.b[0] = {4'b1110, cp[15:12]};
                e.b[1] = {2'b10, cp[11:6]};
                e.b[2] = {2'b10, cp[5:0]};
                e.len  = 3'd3;
            end else begin
                e.b[0] = {5'b11110, cp[20:18]};
                e.b[1] = {2'b10, cp[17:12]};
                e.b[2] = {2'b10, cp[11:6]};
                e.b[3] = {2'b10, cp[5:0]};
                e.len  = 3'd4;
            end
            return e;
        end
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/utf16_to_utf8_encoder_unit.sv =====
// with the queue empty, a unit's job is queued first, then its first byte is registered
// output: one byte per cycle while m_ready is high, 1 to 6 per unit (3 for most bmp text)
// a unit that only holds a high surrogate makes no output
// input takes a unit whenever the two-entry job queue has room, also while bytes drain
// reset: synchronous active-low aresetn clears the held surrogate, the queue and m_valid
`default_nettype none
module utf16_to_utf8_encoder_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [15:0] s_code_unit,
    input  wire logic        s_end_of_text,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_out_byte,
    output logic             m_last_of_run,
    output logic             m_text_done
);

    logic                  push, pop;
    ut8e_pkg::job_t        push_job, head;
    ut8e_pkg::queue_stat_t q_stat;

    ut8e_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_code_unit   (s_code_unit),
        .s_end_of_text (s_end_of_text),
        .q_stat        (q_stat),
        .push          (push),
        .push_job      (push_job)
    );

    ut8e_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .q_stat   (q_stat)
    );

    ut8e_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head          (head),
        .q_stat        (q_stat),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_last_of_run (m_last_of_run),
        .m_text_done   (m_text_done)
    );

endmodule
`default_nettype wire

// ===== hw/rtl/ut8e_front.sv =====
// front end: accepts code units, tracks the held high surrogate, builds byte jobs
`default_nettype none
module ut8e_front (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [ut8e_pkg::UNIT_W-1:0]  s_code_unit,
    input  wire logic                         s_end_of_text,
    input  wire ut8e_pkg::queue_stat_t        q_stat,
    output logic                              push,
    output ut8e_pkg::job_t                    push_job
);

    logic       held_valid_reg, held_valid_next;
    logic [9:0] held_bits_reg, held_bits_next;

    logic                          accept;
    logic                          is_high, is_low, pair, prefix, has_point;
    logic [ut8e_pkg::CP_W-1:0]     cp;
    ut8e_pkg::enc_t                enc;

    assign s_ready = !q_stat.full;
    assign accept  = s_valid && s_ready;

    assign is_high = s_code_unit[15:10] == ut8e_pkg::HIGH_SURR_TAG;
    assign is_low  = s_code_unit[15:10] == ut8e_pkg::LOW_SURR_TAG;
    assign pair    = held_valid_reg && is_low;
    // held high surrogate not completed: replacement first, then the new unit
    assign prefix  = held_valid_reg && !is_low;

    always_comb begin
        cp        = ut8e_pkg::REPL_CP;
        has_point = 1'b1;
        if (pair) begin
            cp = ut8e_pkg::SUPP_BASE + {1'b0, held_bits_reg, s_code_unit[9:0]};
        end else if (is_high) begin
            has_point = s_end_of_text;
        end else if (!is_low) begin
            cp = {5'b0, s_code_unit};
        end
    end

    assign enc = ut8e_pkg::encode_point(cp);

    always_comb begin
        push_job.eot = s_end_of_text;
        if (prefix) begin
            push_job.bytes[0] = ut8e_pkg::REPL_B0;
            push_job.bytes[1] = ut8e_pkg::REPL_B1;
            push_job.bytes[2] = ut8e_pkg::REPL_B2;
            push_job.bytes[3] = enc.b[0];
            push_job.bytes[4] = enc.b[1];
            push_job.bytes[5] = enc.b[2];
            push_job.count    = has_point ? 3'(enc.len + 3'd3) : 3'd3;
        end else begin
            push_job.bytes[0] = enc.b[0];
            push_job.bytes[1] = enc.b[1];
            push_job.bytes[2] = enc.b[2];
            push_job.bytes[3] = enc.b[3];
            push_job.bytes[4] = '0;
            push_job.bytes[5] = '0;
            push_job.count    = has_point ? enc.len : 3'd0;
        end
    end

    // a unit that only gets held makes no job
    assign push = accept && (push_job.count != 3'd0);

    always_comb begin
        held_valid_next = held_valid_reg;
        held_bits_next  = held_bits_reg;
        if (accept) begin
            held_valid_next = !pair && is_high && !s_end_of_text;
            held_bits_next  = held_valid_next ? s_code_unit[9:0] : 10'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_valid_reg <= 1'b0;
            held_bits_reg  <= '0;
        end else begin
            held_valid_reg <= held_valid_next;
            held_bits_reg  <= held_bits_next;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/ut8e_queue.sv =====
// two-entry job queue between front and back
`default_nettype none
module ut8e_queue (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  push,
    input  wire ut8e_pkg::job_t        push_job,
    input  wire logic                  pop,
    output ut8e_pkg::job_t             head,
    output ut8e_pkg::queue_stat_t      q_stat
);

    ut8e_pkg::job_t entry_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     fill_reg, fill_next;

    assign head         = entry_reg[rd_ptr_reg];
    assign q_stat.full  = fill_reg == 2'd2;
    assign q_stat.valid = fill_reg != 2'd0;

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 2'd1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/ut8e_back.sv =====
// back end: head job into byte_reg, one byte per cycle unless stalled
`default_nettype none
module ut8e_back (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire ut8e_pkg::job_t                head,
    input  wire ut8e_pkg::queue_stat_t         q_stat,
    output logic                               pop,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [ut8e_pkg::BYTE_W-1:0]        m_out_byte,
    output logic                               m_last_of_run,
    output logic                               m_text_done
);

    logic [ut8e_pkg::CNT_W-1:0]  idx_reg, idx_next;
    logic                        valid_reg, valid_next;
    logic [ut8e_pkg::BYTE_W-1:0] byte_reg;
    logic                        last_reg, done_reg;

    logic                        load, is_last;
    logic [ut8e_pkg::BYTE_W-1:0] sel_byte;

    assign load    = q_stat.valid && (!valid_reg || m_ready);
    assign is_last = idx_reg == 3'(head.count - 3'd1);
    assign pop     = load && is_last;

    always_comb begin
        unique case (idx_reg)
            3'd0:    sel_byte = head.bytes[0];
            3'd1:    sel_byte = head.bytes[1];
            3'd2:    sel_byte = head.bytes[2];
            3'd3:    sel_byte = head.bytes[3];
            3'd4:    sel_byte = head.bytes[4];
            3'd5:    sel_byte = head.bytes[5];
            default: sel_byte = '0;
        endcase
    end

    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (!valid_reg || m_ready) begin
            valid_next = q_stat.valid;
        end
        if (load) begin
            idx_next = is_last ? 3'd0 : 3'(idx_reg + 3'd1);
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg <= sel_byte;
            last_reg <= is_last;
            done_reg <= is_last && head.eot;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    assign m_valid       = valid_reg;
    assign m_out_byte    = byte_reg;
    assign m_last_of_run = last_reg;
    assign m_text_done   = done_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/ut8e_checker.sv =====
// port-level checks for the utf-16 to utf-8 unit, bound to the top level
`default_nettype none
module ut8e_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [7:0] m_out_byte,
    input wire logic       m_last_of_run,
    input wire logic       m_text_done
);

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    a_out_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte)
            && $stable(m_last_of_run) && $stable(m_text_done))
        else $error("stalled output transfer changed");

    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_text_done |-> m_last_of_run)
        else $error("text_done without last_of_run");

    // a run never ends on a lead byte of a multi-byte sequence
    a_last_not_lead: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last_of_run |-> !m_out_byte[7] || m_out_byte[7:6] == 2'b10)
        else $error("run ended on a lead byte");

    // ascii bytes stand alone, so any byte before the end of a run has bit 7 set
    a_inner_not_ascii: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last_of_run |-> m_out_byte[7])
        else $error("ascii byte inside a run");

endmodule

bind utf16_to_utf8_encoder_unit ut8e_checker u_ut8e_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_out_byte    (m_out_byte),
    .m_last_of_run (m_last_of_run),
    .m_text_done   (m_text_done)
);
`default_nettype wire

// ===== test/tb_utf16_to_utf8_encoder_unit.sv =====
// testbench for the utf-16 to utf-8 encoder unit: directed, random and backpressure tests
`timescale 1ns / 100ps
module tb_utf16_to_utf8_encoder_unit;

    localparam int HOLD_CYCLES   = 300;
    localparam int WATCHDOG_MAX  = 2000;
    localparam int SETTLE_CYCLES = 8;

    typedef enum logic [1:0] {RX_ALWAYS, RX_PATTERN, RX_RANDOM} rx_mode_e;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
        logic       done;
    } utf8_byte_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic [15:0] s_code_unit   = '0;
    logic        s_end_of_text = 1'b0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [7:0]  m_out_byte;
    logic        m_last_of_run;
    logic        m_text_done;

    // encoder state as the block should hold it
    logic [9:0]  held_bits = '0;
    logic        held_on   = 1'b0;

    logic [7:0]  run_bytes[$];
    utf8_byte_t  expected_bytes[$];

    int          errors        = 0;
    int          units_sent    = 0;
    int          bytes_checked = 0;
    int          pairs_joined  = 0;
    int          repl_chars    = 0;
    int          input_stalls  = 0;
    int          burst_left    = 0;
    int          idle_count    = 0;
    int          hold_left     = 0;
    logic        gaps_on       = 1'b0;
    logic        hold_req      = 1'b0;
    rx_mode_e    rx_mode       = RX_ALWAYS;
    logic [15:0] rx_pattern    = 16'hb5a3;
    int          rx_tick       = 0;

    utf16_to_utf8_encoder_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_code_unit   (s_code_unit),
        .s_end_of_text (s_end_of_text),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_last_of_run (m_last_of_run),
        .m_text_done   (m_text_done)
    );

    always #5 aclk = ~aclk;

    task automatic add_run_byte(input logic [7:0] value);
        run_bytes = {run_bytes, value};
    endtask

    task automatic append_code_point(input logic [20:0] cp);
        if (cp < 21'h80) begin
            add_run_byte(8'(cp));
        end else if (cp < 21'h800) begin
            add_run_byte(8'hc0 | 8'(cp >> 6));
            add_run_byte(8'h80 | 8'(cp & 21'h3f));
        end else if (cp < 21'h10000) begin
            add_run_byte(8'he0 | 8'(cp >> 12));
            add_run_byte(8'h80 | 8'((cp >> 6) & 21'h3f));
            add_run_byte(8'h80 | 8'(cp & 21'h3f));
        end else begin
            add_run_byte(8'hf0 | 8'(cp >> 18));
            add_run_byte(8'h80 | 8'((cp >> 12) & 21'h3f));
            add_run_byte(8'h80 | 8'((cp >> 6) & 21'h3f));
            add_run_byte(8'h80 | 8'(cp & 21'h3f));
        end
    endtask

    // works out the bytes one accepted unit causes and queues them
    task automatic predict_utf8_bytes(input logic [15:0] unit, input logic eot);
        logic       is_high;
        logic       is_low;
        logic       joined;
        utf8_byte_t b;
        is_high = (unit[15:10] == ut8e_pkg::HIGH_SURR_TAG);
        is_low  = (unit[15:10] == ut8e_pkg::LOW_SURR_TAG);
        joined  = 1'b0;
        run_bytes.delete();
        if (held_on) begin
            held_on = 1'b0;
            if (is_low) begin
                append_code_point(ut8e_pkg::SUPP_BASE + {1'b0, held_bits, unit[9:0]});
                joined = 1'b1;
                pairs_joined++;
            end else begin
                append_code_point(ut8e_pkg::REPL_CP);
                repl_chars++;
            end
            held_bits = '0;
        end
        if (!joined) begin
            if (is_high && !eot) begin
                held_bits = unit[9:0];
                held_on   = 1'b1;
            end else if (is_high || is_low) begin
                append_code_point(ut8e_pkg::REPL_CP);
                repl_chars++;
            end else begin
                append_code_point({5'd0, unit});
            end
        end
        foreach (run_bytes[k]) begin
            b.value = run_bytes[k];
            b.last  = (k == run_bytes.size() - 1);
            b.done  = b.last && eot;
            expected_bytes = {expected_bytes, b};
        end
    endtask

    task automatic send_unit(input logic [15:0] unit, input logic eot);
        int gap;
        if (gaps_on && burst_left == 0) begin
            gap = $urandom_range(1, 6);
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
            burst_left = $urandom_range(1, 12);
        end else begin
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_code_unit   <= unit;
        s_end_of_text <= eot;
        do begin
            @(posedge aclk);
            if (!s_ready) input_stalls++;
        end while (!s_ready);
        predict_utf8_bytes(unit, eot);
        units_sent++;
        if (burst_left > 0) burst_left--;
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic test_encoding_ranges();
        gaps_on = 1'b0;
        rx_mode = RX_ALWAYS;
        send_unit(16'h0000, 1'b0);
        send_unit(16'h007f, 1'b0);
        send_unit(16'h0080, 1'b0);
        send_unit(16'h07ff, 1'b0);
        send_unit(16'h0800, 1'b0);
        send_unit(16'hd7ff, 1'b0);
        send_unit(16'he000, 1'b0);
        send_unit(16'hfffd, 1'b0);
        send_unit(16'hffff, 1'b1);
        wait_drained();
    endtask

    task automatic test_surrogate_cases();
        gaps_on = 1'b0;
        rx_mode = RX_PATTERN;
        send_unit(16'hd800, 1'b0);
        send_unit(16'hdc00, 1'b0);
        send_unit(16'hdbff, 1'b0);
        send_unit(16'hdfff, 1'b0);
        // high followed by a plain char
        send_unit(16'hd834, 1'b0);
        send_unit(16'h0041, 1'b0);
        // high followed by high, the second then pairs up
        send_unit(16'hd801, 1'b0);
        send_unit(16'hdbfe, 1'b0);
        send_unit(16'hdc05, 1'b0);
        // lone lows
        send_unit(16'hdc00, 1'b0);
        send_unit(16'hdfff, 1'b0);
        // high at end of text
        send_unit(16'hdabc, 1'b1);
        // pair closing a text
        send_unit(16'hd83d, 1'b0);
        send_unit(16'hde00, 1'b1);
        // held high then high at end of text: two replacement chars in one run
        send_unit(16'hd900, 1'b0);
        send_unit(16'hda00, 1'b1);
        wait_drained();
    endtask

    task automatic test_random_text(input int n_units);
        int          len;
        logic        last;
        logic [15:0] unit;
        n_units = units_sent + n_units;
        while (units_sent < n_units) begin
            rx_mode    = rx_mode_e'($urandom_range(0, 2));
            rx_pattern = 16'($urandom()) | 16'h0001;
            gaps_on    = ($urandom_range(0, 3) != 0);
            len        = $urandom_range(1, 10);
            for (int k = 0; k < len; k++) begin
                last = (k == len - 1);
                case ($urandom_range(0, 9))
                    0, 1: unit = 16'($urandom_range(0, 16'h7f));
                    2:    unit = 16'($urandom_range(16'h80, 16'h7ff));
                    3:    unit = 16'($urandom_range(16'h800, 16'hd7ff));
                    4:    unit = 16'($urandom_range(16'he000, 16'hffff));
                    5, 6: begin
                        send_unit({ut8e_pkg::HIGH_SURR_TAG, 10'($urandom())}, 1'b0);
                        unit = {ut8e_pkg::LOW_SURR_TAG, 10'($urandom())};
                    end
                    7:    unit = {ut8e_pkg::LOW_SURR_TAG, 10'($urandom())};
                    8:    unit = {ut8e_pkg::HIGH_SURR_TAG, 10'($urandom())};
                    default: begin
                        unit = 16'($urandom());
                        last = last || ($urandom_range(0, 7) == 0);
                    end
                endcase
                send_unit(unit, last);
            end
        end
        wait_drained();
    endtask

    // receiver holds off while three-byte chars keep coming, so the queue fills
    task automatic test_output_hold();
        gaps_on  = 1'b0;
        rx_mode  = RX_ALWAYS;
        hold_req = 1'b1;
        for (int k = 0; k < 40; k++) send_unit(16'h20ac + 16'(k), k == 39);
        wait_drained();
    endtask

    // receiver ready
    always @(negedge aclk) begin
        rx_tick++;
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS:  m_ready <= 1'b1;
                RX_PATTERN: begin
                    m_ready    <= rx_pattern[rx_tick % 16];
                end
                default:    m_ready <= ($urandom_range(0, 1) == 1);
            endcase
        end
    end

    // compare each byte transfer with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_bytes.size() == 0) begin
                $error("unexpected byte %h with nothing pending", m_out_byte);
                errors++;
            end else begin
                utf8_byte_t exp_b;
                exp_b = expected_bytes.pop_front();
                bytes_checked++;
                if (m_out_byte !== exp_b.value) begin
                    $error("out_byte: expected %h, got %h", exp_b.value, m_out_byte);
                    errors++;
                end
                if (m_last_of_run !== exp_b.last) begin
                    $error("last_of_run: expected %b, got %b", exp_b.last, m_last_of_run);
                    errors++;
                end
                if (m_text_done !== exp_b.done) begin
                    $error("text_done: expected %b, got %b", exp_b.done, m_text_done);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_count = 0;
        end else begin
            idle_count++;
        end
        if (idle_count >= WATCHDOG_MAX) begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_MAX);
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_encoding_ranges();
        test_surrogate_cases();
        test_random_text(360);
        test_output_hold();
        if (expected_bytes.size() != 0) begin
            $error("%0d expected bytes never arrived", expected_bytes.size());
            errors++;
        end
        $display("covered %0d units, %0d bytes checked, %0d pairs joined, %0d replacements",
                 units_sent, bytes_checked, pairs_joined, repl_chars);
        $display("input stalled %0d cycles, %0d errors", input_stalls, errors);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/ut8e_pkg.sv
hw/rtl/ut8e_front.sv
hw/rtl/ut8e_queue.sv
hw/rtl/ut8e_back.sv
hw/rtl/utf16_to_utf8_encoder_unit.sv
hw/rtl/ut8e_checker.sv
test/tb_utf16_to_utf8_encoder_unit.sv
